FILE: rtl/modular_exponentiation_unit_macros.svh
// Assertion macros shared by the modular exponentiation unit's modules.
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at each rising edge outside reset.
`define MEXP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at each rising edge outside reset.
`define MEXP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MEXP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MEXP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/mexp_pkg.sv
// Shared constants and types of the modular exponentiation unit.
package mexp_pkg;

   // Operand width used for every reduction.
   localparam int WIDTH = 32;
   // Width of the external data fields.
   localparam int DATA_W = 32;
   // Bit counter width of the serial multiplier.
   localparam int CNT_W = $clog2(WIDTH);

   // Status of the serial modular multiplier.
   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

FILE: rtl/mexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`include "modular_exponentiation_unit_macros.svh"

module mexp_mulmod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mexp_pkg::WIDTH-1:0]          x,
   input  logic [mexp_pkg::WIDTH-1:0]          y,
   input  logic [mexp_pkg::WIDTH-1:0]          m,
   output logic [mexp_pkg::WIDTH-1:0]          product,
   output mexp_pkg::mm_status_type             status
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [mexp_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [mexp_pkg::WIDTH-1:0]    r_ff, r_in;
   logic [mexp_pkg::WIDTH-1:0]    x_ff, x_in;
   logic [mexp_pkg::WIDTH-1:0]    y_ff, y_in;

   logic [mexp_pkg::WIDTH:0]      dbl;
   logic [mexp_pkg::WIDTH-1:0]    r_dbl;
   logic [mexp_pkg::WIDTH:0]      sum;
   logic [mexp_pkg::WIDTH-1:0]    r_add;

   // Doubling step followed by an optional addition of x, each reduced once.
   always_comb begin
      dbl   = {r_ff, 1'b0};
      r_dbl = (dbl >= {1'b0, m}) ? mexp_pkg::WIDTH'(dbl - {1'b0, m})
                                 : dbl[mexp_pkg::WIDTH-1:0];
      sum   = {1'b0, r_dbl} + {1'b0, x_ff};
      r_add = (sum >= {1'b0, m}) ? mexp_pkg::WIDTH'(sum - {1'b0, m})
                                 : sum[mexp_pkg::WIDTH-1:0];
   end

   // Next state: load on start, then walk through the bits of y.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
         r_in    = '0;
         x_in    = x;
         y_in    = y;
      end else if (busy_ff) begin
         r_in = y_ff[mexp_pkg::WIDTH-1] ? r_add : r_dbl;
         y_in = {y_ff[mexp_pkg::WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers are reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign product     = r_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // The partial product stays reduced throughout the operation.
   `MEXP_ASSERT_IMP(a_partial_reduced, clock, reset, busy_ff && !start, r_ff < m, "partial product not reduced")
   // Completion is never flagged while a product is still being formed.
   `MEXP_ASSERT_IMP(a_done_not_busy, clock, reset, done_ff, !busy_ff, "done while busy")
   // A start always leads to a busy multiplier in the next cycle.
   `MEXP_ASSERT_NXT(a_start_busy, clock, reset, start, busy_ff && !done_ff, "start did not begin")

endmodule

FILE: rtl/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: sequencer, registers and channels.
//
//  Port group  Direction  Handshake          Content
//  req_        in         req_valid/stall    base, exponent
//  rsp_        out        rsp_valid/stall    result, error
//  csr_        in         csr_wr_en          modulus (reset value 1)
//
// An item needs one product for the base reduction, one per set exponent bit and
// one square per bit below the highest set one, and none for a zero modulus.
// Reset is synchronous; req_stall is high from the transfer until the result sits
// in the output register, which holds it while rsp_stall is high.
`include "modular_exponentiation_unit_macros.svh"

module modular_exponentiation_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mexp_pkg::DATA_W-1:0]   req_base,
   input  logic [mexp_pkg::DATA_W-1:0]   req_exponent,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mexp_pkg::DATA_W-1:0]   rsp_result,
   output logic                          rsp_error,
   input  logic                          csr_wr_en,
   input  logic [mexp_pkg::DATA_W-1:0]   csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DISPATCH,
      ST_MUL,
      ST_SQR,
      ST_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [mexp_pkg::DATA_W-1:0]      modulus_ff;
   logic [mexp_pkg::WIDTH-1:0]       e_ff, e_in;
   logic [mexp_pkg::WIDTH-1:0]       acc_ff, acc_in;
   logic [mexp_pkg::WIDTH-1:0]       sq_ff, sq_in;
   logic                             err_ff, err_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mexp_pkg::DATA_W-1:0]      rsp_result_ff, rsp_result_in;
   logic                             rsp_error_ff, rsp_error_in;

   logic [mexp_pkg::WIDTH-1:0]       m;
   logic [mexp_pkg::WIDTH-1:0]       one_mod;
   logic                             req_xfer;
   logic                             mm_start;
   logic [mexp_pkg::WIDTH-1:0]       mm_x;
   logic [mexp_pkg::WIDTH-1:0]       mm_y;
   logic [mexp_pkg::WIDTH-1:0]       mm_product;
   mexp_pkg::mm_status_type          mm_status;

   // Modulus register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mexp_pkg::DATA_W'(1);
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   assign m       = modulus_ff[mexp_pkg::WIDTH-1:0];
   assign one_mod = (m == mexp_pkg::WIDTH'(1)) ? '0 : mexp_pkg::WIDTH'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // Sequencer: reduce the base, then square and multiply per exponent bit.
   always_comb begin
      state_in      = state_ff;
      e_in          = e_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;
      mm_start      = 1'b0;
      mm_x          = acc_ff;
      mm_y          = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               e_in   = req_exponent[mexp_pkg::WIDTH-1:0];
               acc_in = one_mod;
               if (m == '0) begin
                  err_in   = 1'b1;
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  err_in   = 1'b0;
                  mm_start = 1'b1;
                  mm_x     = one_mod;
                  mm_y     = req_base[mexp_pkg::WIDTH-1:0];
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_status.done) begin
               sq_in    = mm_product;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            // A cleared low bit means the multiply for this bit is done.
            if (e_ff == '0) begin
               state_in = ST_DONE;
            end else if (e_ff[0]) begin
               mm_start = 1'b1;
               mm_x     = acc_ff;
               mm_y     = sq_ff;
               state_in = ST_MUL;
            end else begin
               mm_start = 1'b1;
               mm_x     = sq_ff;
               mm_y     = sq_ff;
               state_in = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mm_status.done) begin
               acc_in   = mm_product;
               e_in     = {e_ff[mexp_pkg::WIDTH-1:1], 1'b0};
               state_in = ST_DISPATCH;
            end
         end
         ST_SQR: begin
            if (mm_status.done) begin
               sq_in    = mm_product;
               e_in     = {1'b0, e_ff[mexp_pkg::WIDTH-1:1]};
               state_in = ST_DISPATCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = mexp_pkg::DATA_W'(acc_ff);
               rsp_error_in  = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff          <= e_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      err_ff        <= err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .x       (mm_x),
      .y       (mm_y),
      .m       (m),
      .product (mm_product),
      .status  (mm_status)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_error  = rsp_error_ff;

   // A new product is never started while the multiplier is still working.
   `MEXP_ASSERT_IMP(a_start_idle_mul, clock, reset, mm_start, !mm_status.busy, "multiplier restarted while busy")
   // An error result always carries a zero value.
   `MEXP_ASSERT_IMP(a_error_zero, clock, reset, rsp_valid_ff && rsp_error_ff, rsp_result_ff == '0, "error result not zero")
   // An accepted request always leaves the idle state.
   `MEXP_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_xfer, state_ff != ST_IDLE, "request accepted but still idle")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the modular exponentiation unit.
`timescale 1ns / 1ps

module tb_top;

   // Operands are taken at WIDTH bits before any reduction.
   localparam logic [63:0] OPERAND_MASK = (64'd1 << mexp_pkg::WIDTH) - 64'd1;
   localparam logic [mexp_pkg::DATA_W-1:0] ALL_ONES = '1;
   localparam int MAX_GAP = 10;
   localparam int DRAIN_CYCLES = 50;
   localparam int MAX_REPORTS = 50;

   typedef struct {
      logic [mexp_pkg::DATA_W-1:0] result;
      logic                        error;
   } power_result_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [mexp_pkg::DATA_W-1:0] req_base;
   logic [mexp_pkg::DATA_W-1:0] req_exponent;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [mexp_pkg::DATA_W-1:0] rsp_result;
   logic                        rsp_error;
   logic                        csr_wr_en;
   logic [mexp_pkg::DATA_W-1:0] csr_wr_data;

   // Modulus as the block should hold it, and the results still owed by it.
   logic [mexp_pkg::DATA_W-1:0] modulus_model;
   power_result_type            awaited_powers[$];

   // Idling controls for the request and response sides.
   bit req_idling;
   bit stall_idling;
   bit req_held;
   int req_gap;

   int fail_count;
   int items_sent;
   int results_checked;
   int error_results;
   int moduli_written;

   modular_exponentiation_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result),
      .rsp_error    (rsp_error),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   // Clock generation.
   always #6 clock = ~clock;

   // Base to the power of exponent, reduced by the modulus, with full-width products.
   function automatic power_result_type predict_power(
         input logic [mexp_pkg::DATA_W-1:0] base,
         input logic [mexp_pkg::DATA_W-1:0] exponent,
         input logic [mexp_pkg::DATA_W-1:0] modulus);
      power_result_type r;
      logic [63:0]      m;
      logic [63:0]      acc;
      logic [63:0]      sq;
      logic [63:0]      e;
      m = {32'd0, modulus} & OPERAND_MASK;
      r.result = '0;
      r.error = 1'b0;
      if (m == 64'd0) begin
         r.error = 1'b1;
         return r;
      end
      acc = 64'd1 % m;
      sq = ({32'd0, base} & OPERAND_MASK) % m;
      e = {32'd0, exponent} & OPERAND_MASK;
      while (e != 64'd0) begin
         if (e[0]) begin
            acc = (acc * sq) % m;
         end
         sq = (sq * sq) % m;
         e = e >> 1;
      end
      r.result = acc[mexp_pkg::DATA_W-1:0];
      return r;
   endfunction

   // Prints one line per fault, up to a limit, and counts every one.
   task automatic report_fault(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Offers one request and waits for its transfer. With chain set, valid may stay
   // high so that the next request is offered straight after the transfer.
   task automatic send_item(input logic [mexp_pkg::DATA_W-1:0] base,
                            input logic [mexp_pkg::DATA_W-1:0] exponent,
                            input bit chain);
      if (!req_held) begin
         repeat (req_gap > 0 ? req_gap : 1) @(posedge clock);
      end
      req_base <= base;
      req_exponent <= exponent;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      awaited_powers.insert(awaited_powers.size(),
                            predict_power(base, exponent, modulus_model));
      items_sent++;
      req_gap = req_idling ? $urandom_range(0, MAX_GAP) : 0;
      req_held = chain && (req_gap == 0);
      if (!req_held) begin
         req_valid <= 1'b0;
      end
   endtask

   // Waits until every owed result has been transferred, plus a short margin.
   task automatic wait_drained();
      while (awaited_powers.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes the modulus while the block is idle.
   task automatic write_modulus(input logic [mexp_pkg::DATA_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      modulus_model = value;
      moduli_written++;
   endtask

   // The modulus left by reset is one, so every result must be zero.
   task automatic test_reset_modulus();
      send_item(32'd5, 32'd3, 1'b1);
      send_item(ALL_ONES, ALL_ONES, 1'b1);
      send_item(32'd0, 32'd0, 1'b0);
   endtask

   // A zero modulus must flag an error and give a zero result.
   task automatic test_zero_modulus();
      write_modulus(32'd0);
      send_item(32'd0, 32'd0, 1'b1);
      send_item(ALL_ONES, ALL_ONES, 1'b1);
      send_item(32'd123, 32'd7, 1'b0);
   endtask

   // Extreme operands: zero exponent, zero base, bases at or above the modulus,
   // the largest modulus and the smallest useful one.
   task automatic test_corner_operands();
      logic [mexp_pkg::DATA_W-1:0] corner_list [13][3] = '{
         '{ALL_ONES,      32'd0,          32'd0},
         '{ALL_ONES,      32'd0,          32'd5},
         '{ALL_ONES,      32'd1,          ALL_ONES},
         '{ALL_ONES,      ALL_ONES,       32'd1},
         '{ALL_ONES,      ALL_ONES - 1,   32'd2},
         '{ALL_ONES,      32'h1234_5678,  ALL_ONES},
         '{32'd2,         ALL_ONES,       ALL_ONES},
         '{32'd2,         32'd2,          32'd0},
         '{32'd2,         32'd4,          32'd3},
         '{32'd7,         ALL_ONES,       32'd1},
         '{32'd7,         32'd10,         32'd2},
         '{32'h8000_0000, 32'h7FFF_FFFF,  32'd2},
         '{32'h8000_0000, 32'd3,          32'h0000_001F}
      };
      bit chain;
      for (int i = 0; i < 13; i++) begin
         if (corner_list[i][0] !== modulus_model) begin
            write_modulus(corner_list[i][0]);
         end
         chain = (i < 12) && (corner_list[i + 1][0] === corner_list[i][0]);
         send_item(corner_list[i][1], corner_list[i][2], chain);
      end
   endtask

   // Phases of random traffic, each under a fresh modulus and its own idling mix.
   task automatic test_random_traffic();
      logic [mexp_pkg::DATA_W-1:0] base;
      logic [mexp_pkg::DATA_W-1:0] exponent;
      logic [mexp_pkg::DATA_W-1:0] modulus;
      bit pause_next;
      bit pause_now;
      for (int phase = 0; phase < 11; phase++) begin
         case ($urandom_range(0, 9))
            5:       modulus = $urandom_range(2, 255);
            6:       modulus = ALL_ONES;
            7:       modulus = 32'hFFFF_FFFB;
            8:       modulus = 32'd1;
            9:       modulus = 32'd0;
            default: modulus = $urandom;
         endcase
         write_modulus(modulus);
         req_idling = $urandom_range(0, 2) != 0;
         stall_idling = $urandom_range(0, 2) != 0;
         pause_now = 1'b0;
         for (int i = 0; i < 24; i++) begin
            // Every so often the sender holds back until all results are in.
            pause_next = ($urandom_range(0, 7) == 0) || (phase == 0 && i == 11);
            if (pause_now) begin
               wait_drained();
            end
            case ($urandom_range(0, 3))
               0:       exponent = $urandom;
               1:       exponent = $urandom_range(0, 3);
               default: exponent = $urandom >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 3))
               0:       base = $urandom_range(0, 2);
               1:       base = modulus_model - 1 + $urandom_range(0, 2);
               default: base = $urandom;
            endcase
            send_item(base, exponent, (i < 23) && !pause_next);
            pause_now = pause_next;
         end
      end
   endtask

   // Response side: random stall while a result is offered, then the check on transfer.
   initial begin : result_monitor
      int hold;
      power_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         hold = stall_idling ? $urandom_range(0, MAX_GAP) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         if (awaited_powers.size() == 0) begin
            report_fault($sformatf("result %h error %b with no request outstanding",
                                   rsp_result, rsp_error));
         end else begin
            want = awaited_powers.pop_front();
            results_checked++;
            if (want.error) begin
               error_results++;
            end
            if (rsp_result !== want.result) begin
               report_fault($sformatf("result mismatch, expected %h, got %h",
                                      want.result, rsp_result));
            end
            if (rsp_error !== want.error) begin
               report_fault($sformatf("error flag mismatch, expected %b, got %b",
                                      want.error, rsp_error));
            end
         end
      end
   end

   // Watchdog against a hung block.
   initial begin : watchdog
      #40_000_000;
      $display("Timeout with %0d results outstanding", awaited_powers.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // Reset, the test sequence and the verdict.
   initial begin : main_sequence
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_base <= '0;
      req_exponent <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      modulus_model = 32'd1;
      req_idling = 1'b1;
      stall_idling = 1'b1;
      req_held = 1'b0;
      req_gap = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_modulus();
      test_zero_modulus();
      test_corner_operands();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests under %0d modulus writes and checked %0d results,",
               items_sent, moduli_written, results_checked);
      $display("of which %0d reported a zero modulus; %0d faults seen.",
               error_results, fail_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
